// ----- src/pqenc_pkg.sv -----
package pqenc_pkg;

   localparam int MaxSubvectors = 16;
   localparam int MaxCentroids = 256;
   localparam int MaxSubvectorLength = 8;

   localparam int SubW = $clog2(MaxSubvectors);
   localparam int CentW = $clog2(MaxCentroids);
   localparam int PosW = $clog2(MaxSubvectorLength);
   localparam int AddrW = SubW + CentW + PosW;
   localparam int DepthWords = MaxSubvectors * MaxCentroids * MaxSubvectorLength;

   localparam logic [7:0] CodeLimit = 8'd255;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_DIST   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_LENGTH = 2'd0,
      REG_COUNT  = 2'd1,
      REG_CENT   = 2'd2,
      REG_NONE   = 2'd3
   } reg_type;

   localparam logic KindCode = 1'b0;
   localparam logic KindDist = 1'b1;

endpackage

// ----- src/pq_encode_and_adc_distance_top.sv -----
// Product-quantization encoder and asymmetric distance unit. Codebook loads, unknown commands,
// encode elements that do not complete a subvector and elements outside the configured
// subvectors are handled at the transfer alone. A distance element inside the configured
// subvectors passes through the transfer, the codebook read issue, the registered memory read,
// the squared-difference accumulation and the update of the counters and the result. An encode
// element that completes a subvector starts the nearest-centroid search. The search runs
// through the single codebook read port and one squared-difference accumulator, one codebook
// word per cycle. A stalled result register holds the block in its final state until the
// result is taken. The block drops req_stall only when it is idle and its result register
// is empty or being taken.
// Ties in the search go to the lowest centroid index.
module pq_encode_and_adc_distance_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic signed [15:0] req_value,
   input  logic [3:0]  req_load_subspace,
   input  logic [7:0]  req_load_centroid,
   input  logic [2:0]  req_load_position,
   input  logic [7:0]  req_code_byte,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [3:0]  rsp_subspace_index,
   output logic [7:0]  rsp_code_out,
   output logic [47:0] rsp_distance,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import pqenc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_ACC   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] cb_mem [DepthWords];
   logic [15:0] rd_ff;
   logic [AddrW-1:0] rd_addr;
   logic rd_en;

   logic [15:0] buf_ff [MaxSubvectorLength];

   logic [3:0] len_reg_ff;
   logic [4:0] cnt_reg_ff;
   logic [8:0] cent_reg_ff;

   logic [PosW:0] elem_ff, elem_in;
   logic [SubW:0] subp_ff, subp_in;
   logic [47:0] acc_ff, acc_in;
   logic [47:0] ssum_ff, ssum_in;

   // Search and command context.
   logic [1:0]  cmd_ff;
   logic [15:0] val_ff;
   logic        last_ff;
   logic        compl_ff;
   logic [SubW-1:0] sp_ff;
   logic [CentW-1:0] ci_ff;
   logic [CentW:0] c_ff, c_in;
   logic [PosW-1:0] j_ff, j_in;
   logic [47:0] s_ff, s_in;
   logic [47:0] best_ff, best_in;
   logic [CentW:0] bidx_ff, bidx_in;
   logic        pend_ff, pend_in;   // a read was issued last cycle
   logic        pj_last_ff, pend_jlast;
   logic [PosW-1:0] pj_ff;
   logic [CentW:0] pc_ff;

   logic        out_v_ff, out_v_in;
   logic        out_kind_ff;
   logic [3:0]  out_sub_ff;
   logic [7:0]  out_code_ff;
   logic [47:0] out_dist_ff;
   logic        out_last_ff;
   logic        load_out;
   logic        o_kind;
   logic [3:0]  o_sub;
   logic [7:0]  o_code;
   logic [47:0] o_dist;
   logic        o_last;

   logic [PosW:0] len_c;
   logic [SubW:0] cnt_c;
   logic [CentW:0] ncent_c;
   logic accept;
   logic in_range;
   logic complete;
   logic [15:0] sq_a;
   logic signed [16:0] diff;
   logic [16:0] mag;
   logic [33:0] sq;

   always_comb begin
      len_c = (len_reg_ff == 4'd0) ? (PosW+1)'(1) :
              (len_reg_ff > 4'(MaxSubvectorLength)) ? (PosW+1)'(MaxSubvectorLength)
              : (PosW+1)'(len_reg_ff);
      cnt_c = (cnt_reg_ff == 5'd0) ? (SubW+1)'(1) :
              (cnt_reg_ff > 5'(MaxSubvectors)) ? (SubW+1)'(MaxSubvectors)
              : (SubW+1)'(cnt_reg_ff);
      ncent_c = (cent_reg_ff == 9'd0) ? (CentW+1)'(1) :
                (cent_reg_ff > 9'(MaxCentroids)) ? (CentW+1)'(MaxCentroids)
                : (CentW+1)'(cent_reg_ff);
   end

   assign req_stall = !(state_ff == ST_IDLE) || (out_v_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_range = (subp_ff < cnt_c) && (elem_ff < len_c);
   assign complete = (elem_ff + (PosW+1)'(1)) >= len_c;

   // Shared squared-difference unit.
   assign sq_a = (cmd_ff == CMD_ENCODE) ? buf_ff[pj_ff] : val_ff;
   assign diff = $signed({sq_a[15], sq_a}) - $signed({rd_ff[15], rd_ff});
   assign mag = diff[16] ? 17'(-diff) : 17'(diff);
   assign sq = 34'(mag) * 34'(mag);

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= cb_mem[rd_addr];
      if (accept && req_command == CMD_LOAD) begin
         cb_mem[{req_load_subspace[SubW-1:0], req_load_centroid[CentW-1:0],
                 req_load_position[PosW-1:0]}] <= req_value;
      end
      if (accept && req_command == CMD_ENCODE && in_range)
         buf_ff[elem_ff[PosW-1:0]] <= req_value;
   end

   always_comb begin
      state_in = state_ff;
      elem_in = elem_ff;
      subp_in = subp_ff;
      acc_in = acc_ff;
      ssum_in = ssum_ff;
      c_in = c_ff;
      j_in = j_ff;
      s_in = s_ff;
      best_in = best_ff;
      bidx_in = bidx_ff;
      pend_in = 1'b0;
      pend_jlast = 1'b0;
      rd_en = 1'b0;
      rd_addr = {sp_ff, c_ff[CentW-1:0], j_ff};
      out_v_in = out_v_ff && rsp_stall;
      load_out = 1'b0;
      o_kind = KindCode;
      o_sub = '0;
      o_code = '0;
      o_dist = '0;
      o_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_ENCODE || req_command == CMD_DIST)) begin
               if (in_range && (req_command == CMD_DIST ||
                                (req_command == CMD_ENCODE && complete))) begin
                  state_in = ST_ISSUE;
                  c_in = '0;
                  j_in = '0;
                  s_in = '0;
               end else begin
                  if (in_range) begin
                     elem_in = elem_ff + (PosW+1)'(1);
                  end
                  // A distance element past the configured subvectors still closes the vector.
                  if (req_command == CMD_DIST && req_last_element) begin
                     load_out = 1'b1;
                     o_kind = KindDist;
                     o_dist = acc_ff;
                     o_last = 1'b1;
                     out_v_in = 1'b1;
                  end
                  if (req_last_element) begin
                     elem_in = '0;
                     subp_in = '0;
                     ssum_in = '0;
                     acc_in = '0;
                  end
               end
            end
         end
         ST_ISSUE: begin
            rd_en = 1'b1;
            if (cmd_ff == CMD_DIST) begin
               rd_addr = {sp_ff, ci_ff, elem_ff[PosW-1:0]};
               state_in = ST_WAIT;
            end else begin
               // Issue one codebook word per cycle; the previous read accumulates.
               pend_in = 1'b1;
               pend_jlast = ((PosW+1)'(j_ff) + (PosW+1)'(1)) >= len_c;
               if (pend_jlast) begin
                  j_in = '0;
                  c_in = c_ff + (CentW+1)'(1);
                  if (c_ff + (CentW+1)'(1) >= ncent_c) state_in = ST_WAIT;
               end else begin
                  j_in = j_ff + PosW'(1);
               end
            end
         end
         ST_WAIT: begin
            state_in = (cmd_ff == CMD_DIST) ? ST_ACC : ST_EMIT;
         end
         ST_ACC: begin
            ssum_in = ssum_ff + 48'(sq);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!(out_v_ff && rsp_stall)) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_ENCODE) begin
                  load_out = 1'b1;
                  o_kind = KindCode;
                  o_sub = 4'(sp_ff);
                  o_code = (bidx_ff > (CentW+1)'(CodeLimit)) ? CodeLimit : 8'(bidx_ff);
                  o_last = last_ff || ((SubW+1)'(sp_ff) + (SubW+1)'(1) == cnt_c);
               end else if (compl_ff) begin
                  acc_in = acc_ff + ssum_ff;
               end
               if (cmd_ff == CMD_DIST && last_ff) begin
                  load_out = 1'b1;
                  o_kind = KindDist;
                  o_dist = compl_ff ? acc_ff + ssum_ff : acc_ff;
                  o_last = 1'b1;
               end
               if (compl_ff) begin
                  elem_in = '0;
                  ssum_in = '0;
                  subp_in = subp_ff + (SubW+1)'(1);
               end else begin
                  elem_in = elem_ff + (PosW+1)'(1);
               end
               if (cmd_ff == CMD_DIST && !compl_ff) ssum_in = ssum_ff;
               if (last_ff) begin
                  elem_in = '0;
                  subp_in = '0;
                  ssum_in = '0;
                  acc_in = '0;
               end
               if (load_out) out_v_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Accumulate the word read in the previous cycle during the search.
      if (pend_ff && cmd_ff == CMD_ENCODE) begin
         if (pj_last_ff) begin
            s_in = '0;
            if (pc_ff == '0 || (s_ff + 48'(sq)) < best_ff) begin
               best_in = s_ff + 48'(sq);
               bidx_in = pc_ff;
            end
         end else begin
            s_in = s_ff + 48'(sq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         elem_ff <= '0;
         subp_ff <= '0;
         acc_ff <= '0;
         ssum_ff <= '0;
         out_v_ff <= 1'b0;
         pend_ff <= 1'b0;
         len_reg_ff <= 4'd8;
         cnt_reg_ff <= 5'd16;
         cent_reg_ff <= 9'd256;
      end else begin
         state_ff <= state_in;
         elem_ff <= elem_in;
         subp_ff <= subp_in;
         acc_ff <= acc_in;
         ssum_ff <= ssum_in;
         out_v_ff <= out_v_in;
         pend_ff <= pend_in;
         if (csr_valid && csr_ready) begin
            unique case (reg_type'(csr_index))
               REG_LENGTH: len_reg_ff <= csr_data[3:0];
               REG_COUNT:  cnt_reg_ff <= csr_data[4:0];
               REG_CENT:   cent_reg_ff <= csr_data;
               REG_NONE:   ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      j_ff <= j_in;
      s_ff <= s_in;
      best_ff <= best_in;
      bidx_ff <= bidx_in;
      pj_ff <= j_ff;
      pc_ff <= c_ff;
      pj_last_ff <= pend_jlast;
      if (accept) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
         last_ff <= req_last_element;
         compl_ff <= complete;
         sp_ff <= subp_ff[SubW-1:0];
         ci_ff <= (req_code_byte > 8'(MaxCentroids - 1)) ? CentW'(MaxCentroids - 1)
                  : req_code_byte[CentW-1:0];
      end
      if (load_out) begin
         out_kind_ff <= o_kind;
         out_sub_ff <= o_sub;
         out_code_ff <= o_code;
         out_dist_ff <= o_dist;
         out_last_ff <= o_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_subspace_index = out_sub_ff;
   assign rsp_code_out = out_code_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_last_result = out_last_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_distance)))
      else $error("result changed while stalled");
   a_code_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KindCode) |-> (rsp_distance == '0))
      else $error("code result carries a distance");
endmodule

// ----- tb/sv/pq_checker.sv -----
`timescale 1ns / 1ps

module pq_checker
   import pqenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_value,
   input  logic [3:0]  req_load_subspace,
   input  logic [7:0]  req_load_centroid,
   input  logic [2:0]  req_load_position,
   input  logic [7:0]  req_code_byte,
   input  logic        req_last_element,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [3:0]  rsp_subspace_index,
   input  logic [7:0]  rsp_code_out,
   input  logic [47:0] rsp_distance,
   input  logic        rsp_last_result,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic        kind;
      logic [3:0]  subspace;
      logic [7:0]  code;
      logic [47:0] distance;
      logic        last;
   } pq_result_type;

   logic [15:0] codebook_words [0:DepthWords-1];
   logic [15:0] sub_buf [0:MaxSubvectorLength-1];
   int unsigned elem_pos, sub_pos;
   logic [47:0] dist_acc;
   logic [63:0] partial_sum;
   logic [3:0]  len_reg;
   logic [4:0]  cnt_reg;
   logic [8:0]  cent_reg;
   pq_result_type expected_results [$];

   assign pending = expected_results.size();

   function automatic int unsigned clamp_field(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [33:0] sq_diff(logic [15:0] a, logic [15:0] b);
      logic signed [16:0] d;
      logic [16:0] m;
      d = $signed({a[15], a}) - $signed({b[15], b});
      m = (d < 0) ? 17'(-d) : 17'(d);
      return 34'(m) * 34'(m);
   endfunction

   function automatic int word_addr(int unsigned s, int unsigned c, int unsigned p);
      return int'((s * MaxCentroids + c) * MaxSubvectorLength + p);
   endfunction

   task automatic enqueue_result(pq_result_type item);
      expected_results = {expected_results, item};
   endtask

   // Predicts the block's reaction to one accepted element and queues the result.
   task automatic predict_item();
      cmd_type cmd;
      int unsigned len, cnt, ncent, ci, best_idx;
      logic [63:0] best, s;
      logic complete;
      pq_result_type r;
      cmd = cmd_type'(req_command);
      len = clamp_field(32'(len_reg), MaxSubvectorLength);
      cnt = clamp_field(32'(cnt_reg), MaxSubvectors);
      ncent = clamp_field(32'(cent_reg), MaxCentroids);
      if (cmd == CMD_LOAD) begin
         codebook_words[word_addr(32'(req_load_subspace), 32'(req_load_centroid),
                                  32'(req_load_position))] = req_value;
         return;
      end
      if (cmd == CMD_NONE) return;
      if (sub_pos < cnt && elem_pos < len) begin
         complete = (elem_pos + 1 >= len);
         if (cmd == CMD_ENCODE) begin
            sub_buf[elem_pos] = req_value;
            if (complete) begin
               best = '0;
               best_idx = 0;
               for (int c = 0; c < ncent; c++) begin
                  s = '0;
                  for (int j = 0; j < len; j++)
                     s += 64'(sq_diff(sub_buf[j], codebook_words[word_addr(sub_pos, c, j)]));
                  // Strict compare keeps the lowest index on a tie.
                  if (c == 0 || s < best) begin
                     best = s;
                     best_idx = c;
                  end
               end
               r.kind = KindCode;
               r.subspace = sub_pos[3:0];
               r.code = (best_idx > CodeLimit) ? CodeLimit : best_idx[7:0];
               r.distance = '0;
               r.last = req_last_element || (sub_pos + 1 == cnt);
               enqueue_result(r);
            end
         end else begin
            ci = 32'(req_code_byte);
            partial_sum += 64'(sq_diff(req_value,
                                       codebook_words[word_addr(sub_pos, ci, elem_pos)]));
            if (complete) dist_acc = dist_acc + partial_sum[47:0];
         end
         if (complete) begin
            elem_pos = 0;
            partial_sum = '0;
            sub_pos++;
         end else begin
            elem_pos++;
         end
      end
      if (cmd == CMD_DIST && req_last_element) begin
         r.kind = KindDist;
         r.subspace = '0;
         r.code = '0;
         r.distance = dist_acc;
         r.last = 1'b1;
         enqueue_result(r);
      end
      if (req_last_element) begin
         elem_pos = 0;
         sub_pos = 0;
         partial_sum = '0;
         dist_acc = '0;
      end
   endtask

   task automatic compare_result();
      pq_result_type exp_r, got;
      got = '{rsp_kind, rsp_subspace_index, rsp_code_out, rsp_distance, rsp_last_result};
      if (expected_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result transfer with nothing expected: %p", $realtime, got);
         return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"%0t: mismatch kind %0d/%0d sub %0d/%0d code %0d/%0d ",
                      "distance %0d/%0d last %0d/%0d"},
                     $realtime, exp_r.kind, got.kind, exp_r.subspace, got.subspace,
                     exp_r.code, got.code, exp_r.distance, got.distance,
                     exp_r.last, got.last);
      end
   endtask

   initial begin
      fail_count = 0;
      for (int i = 0; i < DepthWords; i++) codebook_words[i] = '0;
      for (int i = 0; i < MaxSubvectorLength; i++) sub_buf[i] = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         elem_pos = 0;
         sub_pos = 0;
         partial_sum = '0;
         dist_acc = '0;
         len_reg = 4'd8;
         cnt_reg = 5'd16;
         cent_reg = 9'd256;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result();
         if (csr_valid && csr_ready) begin
            case (reg_type'(csr_index))
               REG_LENGTH: len_reg = csr_data[3:0];
               REG_COUNT:  cnt_reg = csr_data[4:0];
               REG_CENT:   cent_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_item();
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pqenc_pkg::*;

   localparam int WatchdogLimit = 50000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_NONE;
   logic signed [15:0] req_value = '0;
   logic [3:0]  req_load_subspace = '0;
   logic [7:0]  req_load_centroid = '0;
   logic [2:0]  req_load_position = '0;
   logic [7:0]  req_code_byte = '0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_subspace_index;
   logic [7:0]  rsp_code_out;
   logic [47:0] rsp_distance;
   logic        rsp_last_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_NONE;
   logic [8:0]  csr_data = '0;

   int fail_count, pending;
   int idle_cycles = 0;
   int stall_left = 0, run_left = 0;
   bit quiet = 1'b0;
   bit loaded [0:DepthWords-1];

   always #6 clock = ~clock;

   pq_encode_and_adc_distance_top dut (.*);

   pq_checker u_checker (.*);

   // Receiver stalls come in bursts separated by runs of free cycles.
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left <= int'($urandom_range(0, 9));
         rsp_stall <= 1'b1;
      end else begin
         run_left <= int'($urandom_range(1, 30));
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic int clamp_field(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [15:0] pick_value();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 16)) - 16'd8;
   endfunction

   function automatic logic [7:0] pick_code(int ncent);
      if ($urandom_range(0, 7) == 0) return CodeLimit;
      return 8'($urandom_range(0, ncent - 1));
   endfunction

   task automatic send(cmd_type cmd, logic [15:0] val, logic [3:0] ls, logic [7:0] lc,
                       logic [2:0] lp, logic [7:0] code, logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= val;
      req_load_subspace <= ls;
      req_load_centroid <= lc;
      req_load_position <= lp;
      req_code_byte <= code;
      req_last_element <= last;
      if (cmd == CMD_LOAD) loaded[(ls * MaxCentroids + lc) * MaxSubvectorLength + lp] = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic element(cmd_type cmd, logic [15:0] val, logic [7:0] code, logic last);
      send(cmd, val, 4'($urandom), 8'($urandom), 3'($urandom), code, last);
   endtask

   // Holds off until every expected result has been transferred and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(logic [8:0] len, logic [8:0] cnt, logic [8:0] cent);
      logic [8:0] vals [3];
      vals = '{len, cnt, cent};
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Writes every codebook word that the current settings can read.
   task automatic preload(int len, int cnt, int ncent);
      for (int s = 0; s < cnt; s++)
         for (int c = 0; c <= 255; c++)
            if (c < ncent || c == 255)
               for (int p = 0; p < len; p++)
                  if (!loaded[(s * MaxCentroids + c) * MaxSubvectorLength + p])
                     send(CMD_LOAD, pick_value(), 4'(s), 8'(c), 3'(p), 8'($urandom),
                          1'($urandom));
   endtask

   task automatic run_phase(int len_raw, int cnt_raw, int cent_raw, int nrand, int quiet_from);
      int len, cnt, ncent, items, total, n, choice;
      cmd_type mode;
      logic [7:0] code;
      len = clamp_field(len_raw, MaxSubvectorLength);
      cnt = clamp_field(cnt_raw, MaxSubvectors);
      ncent = clamp_field(cent_raw, MaxCentroids);
      configure(9'(len_raw), 9'(cnt_raw), 9'(cent_raw));
      preload(len, cnt, ncent);
      items = 0;
      while (items < nrand) begin
         if (items >= quiet_from) quiet = 1'b1;
         choice = int'($urandom_range(0, 99));
         if (choice < 85) begin
            mode = (choice < 45) ? CMD_ENCODE : CMD_DIST;
            total = len * cnt;
            case ($urandom_range(0, 6))
               0: n = int'($urandom_range(1, total));
               1: n = total + int'($urandom_range(1, 3));
               default: n = total;
            endcase
            code = pick_code(ncent);
            for (int i = 0; i < n; i++) begin
               if (i % len == 0) code = pick_code(ncent);
               element(mode, pick_value(), code, i == n - 1);
            end
            items += n;
         end else begin
            case ($urandom_range(0, 2))
               0: send(CMD_LOAD, pick_value(), 4'($urandom_range(0, cnt - 1)),
                       pick_code(ncent), 3'($urandom_range(0, len - 1)), 8'($urandom),
                       1'($urandom));
               1: send(CMD_NONE, 16'($urandom), 4'($urandom), 8'($urandom), 3'($urandom),
                       8'($urandom), 1'($urandom));
               default: element($urandom_range(0, 1) ? CMD_ENCODE : CMD_DIST, pick_value(),
                                pick_code(ncent), $urandom_range(0, 3) == 0);
            endcase
            items++;
         end
      end
      // Close any open vector so the next settings start from clean counters.
      element(CMD_ENCODE, pick_value(), 8'd0, 1'b1);
   endtask

   initial begin
      for (int i = 0; i < DepthWords; i++) loaded[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(9'd2, 9'd2, 9'd4);
      preload(2, 2, 4);
      send(CMD_LOAD, 16'sh7fff, 4'd0, 8'd0, 3'd0, 8'd0, 1'b0);
      send(CMD_LOAD, 16'sh8000, 4'd0, 8'd1, 3'd0, 8'hff, 1'b1);
      send(CMD_LOAD, 16'hffff, 4'hf, 8'hff, 3'd7, 8'hff, 1'b1);
      element(CMD_ENCODE, 16'sh8000, 8'd0, 1'b0);
      element(CMD_ENCODE, 16'sh7fff, 8'd0, 1'b0);
      element(CMD_ENCODE, 16'd0, 8'd0, 1'b0);
      element(CMD_ENCODE, 16'd0, 8'd0, 1'b1);
      element(CMD_DIST, 16'sh8000, 8'hff, 1'b0);
      element(CMD_DIST, 16'sh7fff, 8'hff, 1'b0);
      element(CMD_DIST, 16'sh7fff, 8'd0, 1'b0);
      element(CMD_DIST, 16'd0, 8'd3, 1'b1);
      element(CMD_ENCODE, 16'sh7fff, 8'd0, 1'b1);
      element(CMD_DIST, 16'sh8000, 8'd1, 1'b1);
      send(CMD_NONE, 16'hffff, 4'hf, 8'hff, 3'd7, 8'hff, 1'b1);
      for (int i = 0; i < 5; i++) element(CMD_ENCODE, pick_value(), 8'd0, i == 4);
      for (int i = 0; i < 5; i++) element(CMD_DIST, pick_value(), pick_code(4), i == 4);
      element(CMD_ENCODE, 16'd0, 8'd0, 1'b0);
      element(CMD_DIST, 16'd5, 8'd2, 1'b0);
      element(CMD_ENCODE, 16'd1, 8'd0, 1'b1);

      // The codebook loads of the phases below add close to a thousand items.
      run_phase(2, 2, 4, 80, 1 << 30);
      run_phase(0, 0, 1, 60, 1 << 30);
      run_phase(15, 31, 3, 90, 1 << 30);
      run_phase(1, 1, 511, 70, 1 << 30);
      run_phase(3, 5, 8, 90, 1 << 30);
      run_phase(5, 3, 0, 60, 1 << 30);
      run_phase(4, 4, 16, 90, 40);

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
